### rtl/skvet_pkg.sv
// Package for the salience key/value eviction tracker.
// Holds field widths, reset values, action and register codes and the state type.
// No dependencies; every other file of the block imports it.
package skvet_pkg;

  // Field widths of the item and result words.
  localparam int ACTION_W   = 3;
  localparam int LAYER_W    = 5;
  localparam int POSITION_W = 12;
  localparam int WEIGHT_W   = 17;
  localparam int STATUS_W   = 1;
  localparam int PRUNED_W   = 18;
  localparam int GLEN_W     = 13;

  // Configuration register widths and port shape.
  localparam int THRESH_W   = 32;
  localparam int DECAY_W    = 17;
  localparam int LIU_W      = 6;
  localparam int CTX_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Default sizes of the store.
  localparam int LAYERS_DEF      = 32;
  localparam int MAX_CONTEXT_DEF = 4096;
  localparam int PINNED_DEF      = 4;

  // Salience scores are Q16.16.
  localparam int SAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam logic [SAL_W-1:0] SAL_ONE = 32'h0001_0000;

  // Register values after reset.
  localparam logic [THRESH_W-1:0] THRESH_RST = 32'd3277;
  localparam logic [DECAY_W-1:0]  DECAY_RST  = 17'd62259;
  localparam logic [LIU_W-1:0]    LIU_RST    = 6'd32;
  localparam logic [CTX_W-1:0]    CTX_RST    = 13'd4096;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK  = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_REJ = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE       = 3'd0,
    ACT_APPEND      = 3'd1,
    ACT_SALIENCE    = 3'd2,
    ACT_PRUNE_LAYER = 3'd3,
    ACT_PRUNE_ALL   = 3'd4,
    ACT_RESET       = 3'd5
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRUNE_THRESHOLD = 2'd0,
    CFG_DECAY_FACTOR    = 2'd1,
    CFG_LAYERS_IN_USE   = 2'd2,
    CFG_CONTEXT_LIMIT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SAL_MUL,
    ST_SAL_WR,
    ST_PRUNE,
    ST_DRAIN,
    ST_HOLD
  } state_e;

endpackage

### rtl/skvet_if.sv
// Handshake channels of the salience key/value eviction tracker.
// The item channel carries one command word, the result channel one response word.
// Depends on skvet_pkg for the field widths.
interface skvet_item_if;
  import skvet_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [LAYER_W-1:0]    layer;
  logic [POSITION_W-1:0] position;
  logic [WEIGHT_W-1:0]   weight;

  modport source (output valid, output action, output layer, output position,
                  output weight, input ready);
  modport sink   (input valid, input action, input layer, input position,
                  input weight, output ready);
endinterface

interface skvet_result_if;
  import skvet_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PRUNED_W-1:0] evict_count;
  logic [GLEN_W-1:0]   global_length;

  modport source (output valid, output status, output evict_count,
                  output global_length, input ready);
  modport sink   (input valid, input status, input evict_count,
                  input global_length, output ready);
endinterface

### rtl/salience_kv_eviction_tracker_core.sv
// Top level of the salience key/value eviction tracker.
// Uses skvet_pkg and the channel interfaces in skvet_if.sv.
// Holds the entry memory, the command sequencer and the configuration registers.

// One item is handled at a time; a finished result waits in an output register
// while the next word is already taken. A salience update reads the entry from
// memory, does a 32x17 multiply, then a saturating add and write back. A prune
// walks positions PINNED up to the global length minus one, in the given layer
// or in every layer in use, and walks nothing when the global length is at most
// PINNED or no layer is in use. The prune walk and the reset action go through
// the single entry memory one entry per cycle. After the reset pin is released
// the same clearing pass writes all LAYERS * MAX_CONTEXT entries (131072 with
// the default sizes) before the first word is taken; configuration writes are
// taken at any time.
module salience_kv_eviction_tracker_core #(
  parameter int LAYERS      = skvet_pkg::LAYERS_DEF,
  parameter int MAX_CONTEXT = skvet_pkg::MAX_CONTEXT_DEF,
  parameter int PINNED      = skvet_pkg::PINNED_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [skvet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [skvet_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  skvet_item_if.sink                       item_i,
  skvet_result_if.source                   result_o
);
  import skvet_pkg::*;

  localparam int DEPTH   = LAYERS * MAX_CONTEXT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LAY_W   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int POS_W   = $clog2(MAX_CONTEXT);
  localparam int TOT_W   = $clog2(MAX_CONTEXT + 1);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (TOT_W > CTX_W) ? TOT_W : CTX_W;
  localparam int ENTRY_W = SAL_W + 1;
  localparam int PROD_W  = SAL_W + DECAY_W;
  localparam int SUM_W   = PROD_W - FRAC_W + 1;

  // Memory address of one (layer, position) entry.
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [LAY_W-1:0] l,
                                                   input logic [POS_W-1:0] p);
    return ADDR_W'(l * MAX_CONTEXT) + ADDR_W'(p);
  endfunction

  // Control state.
  state_e               state_q, state_d;
  logic [TOT_W-1:0]     total_q, total_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [LAY_W-1:0]     wlay_q, wlay_d;
  logic [POS_W-1:0]     wpos_q, wpos_d;
  logic                 chk_v_q, chk_v_d;
  logic [ADDR_W-1:0]    clr_addr_q, clr_addr_d;
  logic                 clr_item_q, clr_item_d;
  logic                 out_valid_q, out_valid_d;

  // Configuration registers.
  logic [THRESH_W-1:0]  thr_q;
  logic [DECAY_W-1:0]   decay_q;
  logic [LIU_W-1:0]     liu_q;
  logic [CTX_W-1:0]     ctx_q;

  // Latched item and datapath registers.
  logic [ACTION_W-1:0]   act_q, act_d;
  logic [LAYER_W-1:0]    lay_q, lay_d;
  logic [POSITION_W-1:0] pos_in_q, pos_in_d;
  logic [WEIGHT_W-1:0]   wt_q, wt_d;
  logic [ADDR_W-1:0]     op_addr_q, op_addr_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d, pend_status_q, pend_status_d;
  logic [PRUNED_W-1:0]   out_pruned_q, out_pruned_d, pend_pruned_q, pend_pruned_d;
  logic [GLEN_W-1:0]     out_glen_q, out_glen_d, pend_glen_q, pend_glen_d;

  // Entry memory: active bit over the Q16.16 score.
  logic [ENTRY_W-1:0]   entry_mem [DEPTH];
  logic [ENTRY_W-1:0]   rd_data_q;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0]   mem_wdata;

  // Decode helpers.
  logic                 layer_ok, wr_ok, sal_ok, prune_empty, pos_last, lay_last, hit;
  logic                 out_free, fin;
  logic [STATUS_W-1:0]  fin_status;
  logic [CNT_W-1:0]     fin_cnt;
  logic [CMP_W-1:0]     wpos;
  logic [TOT_W-1:0]     new_len;
  logic [ADDR_W-1:0]    item_addr, walk_addr;
  logic [POS_W-1:0]     start_pos;
  logic [SUM_W-1:0]     sal_sum;
  logic [SAL_W-1:0]     sal_new;

  // Range checks on the latched item.
  always_comb begin
    layer_ok    = (32'(lay_q) < 32'(liu_q)) && (32'(lay_q) < LAYERS);
    wpos        = (act_q == ACT_APPEND) ? CMP_W'(total_q) : CMP_W'(pos_in_q);
    wr_ok       = layer_ok && (wpos < CMP_W'(ctx_q)) && (wpos < CMP_W'(MAX_CONTEXT));
    sal_ok      = layer_ok && (CMP_W'(pos_in_q) <= CMP_W'(total_q))
                  && (CMP_W'(pos_in_q) < CMP_W'(MAX_CONTEXT));
    new_len     = TOT_W'(wpos) + TOT_W'(1);
    item_addr   = entry_addr(LAY_W'(lay_q), POS_W'(wpos));
    prune_empty = (32'(total_q) <= PINNED);
    start_pos   = POS_W'(PINNED);
    walk_addr   = entry_addr(wlay_q, wpos_q);
    pos_last    = (TOT_W'(wpos_q) + TOT_W'(1)) == total_q;
    lay_last    = (act_q == ACT_PRUNE_LAYER) || (32'(wlay_q) + 32'd1 >= 32'(liu_q))
                  || (32'(wlay_q) + 32'd1 >= LAYERS);
  end

  // Decayed score plus weight, saturated to 32 bits.
  always_comb begin
    sal_sum = SUM_W'(prod_q >> FRAC_W) + SUM_W'(wt_q);
    sal_new = (|sal_sum[SUM_W-1:SAL_W]) ? '1 : sal_sum[SAL_W-1:0];
  end

  // Sequencer: next state, memory port control and result loading.
  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    cnt_d        = cnt_q;
    wlay_d       = wlay_q;
    wpos_d       = wpos_q;
    chk_v_d      = 1'b0;
    clr_addr_d   = clr_addr_q;
    clr_item_d   = clr_item_q;
    act_d        = act_q;
    lay_d        = lay_q;
    pos_in_d     = pos_in_q;
    wt_d         = wt_q;
    op_addr_d    = op_addr_q;
    prod_d       = prod_q;
    mem_we       = 1'b0;
    mem_waddr    = op_addr_q;
    mem_wdata    = {1'b1, SAL_ONE};
    mem_re       = 1'b0;
    mem_raddr    = item_addr;
    fin          = 1'b0;
    fin_status   = STATUS_OK;
    fin_cnt      = '0;
    out_free     = !out_valid_q || result_o.ready;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_status_d = out_status_q;
    out_pruned_d = out_pruned_q;
    out_glen_d   = out_glen_q;
    pend_status_d = pend_status_q;
    pend_pruned_d = pend_pruned_q;
    pend_glen_d   = pend_glen_q;

    // Prune check stage: the entry read last cycle is tested and, if active and below the threshold, retired.
    hit = chk_v_q && rd_data_q[SAL_W] && (rd_data_q[SAL_W-1:0] < thr_q);
    if (hit) begin
      mem_we    = 1'b1;
      mem_waddr = op_addr_q;
      mem_wdata = {1'b0, rd_data_q[SAL_W-1:0]};
      cnt_d     = cnt_q + CNT_W'(1);
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = {1'b1, SAL_ONE};
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
          if (clr_item_q) begin
            fin = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          clr_addr_d = clr_addr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (item_i.valid) begin
          act_d    = item_i.action;
          lay_d    = item_i.layer;
          pos_in_d = item_i.position;
          wt_d     = item_i.weight;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (act_q)
          ACT_WRITE, ACT_APPEND: begin
            if (wr_ok) begin
              mem_we    = 1'b1;
              mem_waddr = item_addr;
              mem_wdata = {1'b1, SAL_ONE};
              if (new_len > total_q) begin
                total_d = new_len;
              end
            end
            fin        = 1'b1;
            fin_status = wr_ok ? STATUS_OK : STATUS_REJ;
          end
          ACT_SALIENCE: begin
            if (sal_ok) begin
              mem_re    = 1'b1;
              mem_raddr = item_addr;
              op_addr_d = item_addr;
              state_d   = ST_SAL_MUL;
            end else begin
              fin        = 1'b1;
              fin_status = STATUS_REJ;
            end
          end
          ACT_PRUNE_LAYER, ACT_PRUNE_ALL: begin
            if ((act_q == ACT_PRUNE_LAYER) && !layer_ok) begin
              fin        = 1'b1;
              fin_status = STATUS_REJ;
            end else if (prune_empty || (liu_q == '0)) begin
              fin = 1'b1;
            end else begin
              wlay_d  = (act_q == ACT_PRUNE_LAYER) ? LAY_W'(lay_q) : '0;
              wpos_d  = start_pos;
              cnt_d   = '0;
              state_d = ST_PRUNE;
            end
          end
          ACT_RESET: begin
            total_d    = '0;
            clr_addr_d = '0;
            clr_item_d = 1'b1;
            state_d    = ST_CLEAR;
          end
          default: begin
            fin        = 1'b1;
            fin_status = STATUS_REJ;
          end
        endcase
      end
      ST_SAL_MUL: begin
        prod_d  = PROD_W'(rd_data_q[SAL_W-1:0]) * PROD_W'(decay_q);
        state_d = ST_SAL_WR;
      end
      ST_SAL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = op_addr_q;
        mem_wdata = {rd_data_q[SAL_W], sal_new};
        fin       = 1'b1;
      end
      ST_PRUNE: begin
        // Issue one read per cycle; the check stage follows in the next cycle.
        mem_re    = 1'b1;
        mem_raddr = walk_addr;
        op_addr_d = walk_addr;
        chk_v_d   = 1'b1;
        if (pos_last) begin
          if (lay_last) begin
            state_d = ST_DRAIN;
          end else begin
            wlay_d = wlay_q + LAY_W'(1);
            wpos_d = start_pos;
          end
        end else begin
          wpos_d = wpos_q + POS_W'(1);
        end
      end
      ST_DRAIN: begin
        fin     = 1'b1;
        fin_cnt = cnt_d;
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_pruned_d = pend_pruned_q;
          out_glen_d   = pend_glen_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A finished item goes to the output register, or waits if it is still full.
    if (fin) begin
      clr_item_d = 1'b0;
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_status_d = fin_status;
        out_pruned_d = PRUNED_W'(fin_cnt);
        out_glen_d   = GLEN_W'(total_d);
        state_d      = ST_IDLE;
      end else begin
        pend_status_d = fin_status;
        pend_pruned_d = PRUNED_W'(fin_cnt);
        pend_glen_d   = GLEN_W'(total_d);
        state_d       = ST_HOLD;
      end
    end
  end

  // Control registers; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      total_q     <= '0;
      cnt_q       <= '0;
      wlay_q      <= '0;
      wpos_q      <= '0;
      chk_v_q     <= 1'b0;
      clr_addr_q  <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      wlay_q      <= wlay_d;
      wpos_q      <= wpos_d;
      chk_v_q     <= chk_v_d;
      clr_addr_q  <= clr_addr_d;
      clr_item_q  <= clr_item_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESH_RST;
      decay_q <= DECAY_RST;
      liu_q   <= LIU_RST;
      ctx_q   <= CTX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRUNE_THRESHOLD: thr_q   <= cfg_wdata_i[THRESH_W-1:0];
        CFG_DECAY_FACTOR:    decay_q <= cfg_wdata_i[DECAY_W-1:0];
        CFG_LAYERS_IN_USE:   liu_q   <= cfg_wdata_i[LIU_W-1:0];
        CFG_CONTEXT_LIMIT:   ctx_q   <= cfg_wdata_i[CTX_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    act_q         <= act_d;
    lay_q         <= lay_d;
    pos_in_q      <= pos_in_d;
    wt_q          <= wt_d;
    op_addr_q     <= op_addr_d;
    prod_q        <= prod_d;
    out_status_q  <= out_status_d;
    out_pruned_q  <= out_pruned_d;
    out_glen_q    <= out_glen_d;
    pend_status_q <= pend_status_d;
    pend_pruned_q <= pend_pruned_d;
    pend_glen_q   <= pend_glen_d;
  end

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= entry_mem[mem_raddr];
    end
  end

  assign item_i.ready           = (state_q == ST_IDLE);
  assign result_o.valid         = out_valid_q;
  assign result_o.status        = out_status_q;
  assign result_o.evict_count   = out_pruned_q;
  assign result_o.global_length = out_glen_q;

endmodule

### rtl/skvet_checker.sv
// Port-level checks for the salience key/value eviction tracker.
// Depends on skvet_pkg; bound to salience_kv_eviction_tracker_core below.
// Watches the item and result handshakes over time.
module skvet_checker #(
  parameter int MAX_CONTEXT = skvet_pkg::MAX_CONTEXT_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [skvet_pkg::STATUS_W-1:0] out_status_i,
  input logic [skvet_pkg::PRUNED_W-1:0] out_pruned_i,
  input logic [skvet_pkg::GLEN_W-1:0]   out_glen_i
);
  import skvet_pkg::*;

  // Only one word is in work at a time: taking one drops ready.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("item taken while another is in work");

  // A stalled result holds its word.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_status_i)
      && $stable(out_pruned_i) && $stable(out_glen_i)))
    else $error("result word changed while stalled");

  // A rejected word never reports pruned entries.
  a_reject_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i == STATUS_REJ)) |-> (out_pruned_i == '0))
    else $error("rejected word carries a pruned count");

  // The global length never exceeds the context capacity.
  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(out_glen_i) <= MAX_CONTEXT))
    else $error("global length beyond capacity");

endmodule

bind salience_kv_eviction_tracker_core skvet_checker #(
  .MAX_CONTEXT (MAX_CONTEXT)
) u_skvet_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_status_i (result_o.status),
  .out_pruned_i (result_o.evict_count),
  .out_glen_i   (result_o.global_length)
);
